[src/birs_pkg.sv]
// shared types and constants for the bank interleaved request scheduler
// no dependencies; used by every module of the block

package birs_pkg;

	localparam int DEF_NUM_BANKS   = 4;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_ID_BITS     = 8;

	localparam logic [15:0] ROW_OPEN_DELAY_RST = 16'd10;
	localparam logic [2:0]  BANKS_IN_USE_RST   = 3'd4;

	typedef enum logic [0:0] {
		CFG_ROW_OPEN_DELAY = 1'b0,
		CFG_BANKS_IN_USE   = 1'b1
	} cfg_index_t;

	typedef enum logic [0:0] {
		REQ_NEW  = 1'b0,
		REQ_TICK = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic [0:0] req_type;
		logic [7:0] request_id;
	} item_t;

	typedef struct packed {
		logic [7:0] done_id;
		logic [1:0] done_bank;
		logic [0:0] dropped;
		logic [0:0] last;
	} result_t;

	// command passed from the front end to the bank engine
	typedef struct packed {
		logic       is_tick;
		logic [7:0] id;
		logic [2:0] bank;
	} cmd_t;

endpackage

[src/birs_front.sv]
// front end: accepts input beats, picks the round-robin bank for requests
// depends on birs_pkg

module birs_front import birs_pkg::*; #(
	parameter int NUM_BANKS = DEF_NUM_BANKS,
	parameter int BANK_W    = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	input  logic [BANK_W:0]   n_act,
	output logic              push,
	input  logic              push_ready,
	output cmd_t              push_cmd
);

	logic [BANK_W-1:0]   next_bank_q;
	logic [BANK_W-1:0]   bank;
	logic [BANK_W:0]     bank_inc;
	logic [BANK_W+2:0]   bank_x;

	assign item_ready = push_ready;
	assign push       = item_valid && push_ready;

	always_comb begin
		bank = next_bank_q;
		if ({1'b0, next_bank_q} >= n_act) begin
			bank = '0;
		end
		bank_inc = {1'b0, bank} + 1'b1;
		bank_x   = {3'b000, bank};
		push_cmd.is_tick = (item.req_type == REQ_TICK);
		push_cmd.id      = item.request_id;
		push_cmd.bank    = bank_x[2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_bank_q <= '0;
		end else if (push && item.req_type == REQ_NEW) begin
			if (bank_inc >= n_act) begin
				next_bank_q <= '0;
			end else begin
				next_bank_q <= bank_inc[BANK_W-1:0];
			end
		end
	end

endmodule

[src/birs_cmd_fifo.sv]
// two-entry command queue between the front end and the bank engine
// depends on birs_pkg

module birs_cmd_fifo import birs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic cmd_valid,
	input  logic pop,
	output cmd_t cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign push_ready = (fill_q != 2'd2);
	assign cmd_valid  = (fill_q != 2'd0);
	assign cmd        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

[src/birs_back.sv]
// bank engine: per-bank queues in a memory, busy timers, result register
// depends on birs_pkg; fed by birs_cmd_fifo

module birs_back import birs_pkg::*; #(
	parameter int NUM_BANKS   = DEF_NUM_BANKS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS,
	parameter int BANK_W      = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  cmd_t            cmd,
	output logic            pop,
	input  logic [BANK_W:0] n_act,
	input  logic [15:0]     dly,
	output logic            result_valid,
	input  logic            result_ready,
	output result_t         result
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [ID_BITS-1:0]  mem [NUM_BANKS][QUEUE_DEPTH];
	logic [ID_BITS-1:0]  rd_q;
	logic                cap_pend_q;
	logic [BANK_W-1:0]   cap_bank_q;

	logic [PTR_W-1:0]    head_q  [NUM_BANKS];
	logic [CNT_W-1:0]    count_q [NUM_BANKS];
	logic [15:0]         cd_q    [NUM_BANKS];
	logic [NUM_BANKS-1:0] sv_q;
	logic [ID_BITS-1:0]  sid_q   [NUM_BANKS];
	logic [BANK_W-1:0]   vis_q;

	logic                rv_q;
	result_t             res_q;

	logic                can_emit;
	logic [BANK_W-1:0]   req_bank;
	logic                req_full;
	logic [ID_BITS+7:0]  in_id_x;
	logic [ID_BITS-1:0]  wr_id;
	logic [PTR_W:0]      pos_sum;
	logic [PTR_W-1:0]    wr_pos;
	logic                do_write;
	logic                do_drop;

	logic [15:0]         cd_dec;
	logic                fin;
	logic                emit_c;
	logic                start;
	logic                tick_go;
	logic                tick_end;
	logic                later;
	logic [ID_BITS-1:0]  emit_id;
	logic [ID_BITS+7:0]  emit_id_x;
	logic [BANK_W+1:0]   bank_x;
	logic [PTR_W:0]      head_inc;
	result_t             res_d;

	always_comb begin
		can_emit = !rv_q || result_ready;

		// request path
		req_bank = cmd.bank[BANK_W-1:0];
		req_full = (count_q[req_bank] == CNT_W'(QUEUE_DEPTH));
		in_id_x  = {{ID_BITS{1'b0}}, cmd.id};
		wr_id    = in_id_x[ID_BITS-1:0];
		pos_sum  = (PTR_W+1)'(head_q[req_bank]) + (PTR_W+1)'(count_q[req_bank]);
		if (pos_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
			pos_sum = pos_sum - (PTR_W+1)'(QUEUE_DEPTH);
		end
		wr_pos   = pos_sum[PTR_W-1:0];
		do_write = cmd_valid && !cmd.is_tick && !req_full;
		do_drop  = cmd_valid && !cmd.is_tick && req_full && can_emit;

		// tick path, one bank per cycle while no completion is held waiting for the result register
		cd_dec   = (cd_q[vis_q] != 16'd0) ? cd_q[vis_q] - 16'd1 : 16'd0;
		fin      = (cd_dec == 16'd0);
		emit_c   = fin && sv_q[vis_q];
		start    = fin && (count_q[vis_q] != '0);
		tick_go  = cmd_valid && cmd.is_tick && (!emit_c || can_emit);
		tick_end = (({1'b0, vis_q}) + 1'b1) == n_act;
		head_inc = {1'b0, head_q[vis_q]} + 1'b1;

		later = 1'b0;
		for (int j = 0; j < NUM_BANKS; j++) begin
			if (j > int'(vis_q) && j < int'(n_act) && sv_q[j] && cd_q[j] <= 16'd1) begin
				later = 1'b1;
			end
		end

		// read data not yet captured into the serving slot
		emit_id = (cap_pend_q && cap_bank_q == vis_q) ? rd_q : sid_q[vis_q];

		res_d = '0;
		if (cmd.is_tick) begin
			emit_id_x     = {8'd0, emit_id};
			bank_x        = {2'b00, vis_q};
			res_d.last    = !later;
			res_d.dropped = 1'b0;
		end else begin
			emit_id_x     = {8'd0, wr_id};
			bank_x        = {2'b00, req_bank};
			res_d.last    = 1'b1;
			res_d.dropped = 1'b1;
		end
		res_d.done_id   = emit_id_x[7:0];
		res_d.done_bank = bank_x[1:0];

		pop = do_write || do_drop || (tick_go && tick_end);
	end

	assign result_valid = rv_q;
	assign result       = res_q;

	// bank queue memory
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[req_bank][wr_pos] <= wr_id;
		end
		if (tick_go && start) begin
			rd_q <= mem[vis_q][head_q[vis_q]];
		end
	end

	always_ff @(posedge clk) begin
		if (cap_pend_q) begin
			sid_q[cap_bank_q] <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if ((tick_go && emit_c) || do_drop) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BANKS; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
				cd_q[i]    <= '0;
			end
			sv_q       <= '0;
			vis_q      <= '0;
			rv_q       <= 1'b0;
			cap_pend_q <= 1'b0;
			cap_bank_q <= '0;
		end else begin
			cap_pend_q <= tick_go && start;
			cap_bank_q <= vis_q;

			if ((tick_go && emit_c) || do_drop) begin
				rv_q <= 1'b1;
			end else if (result_ready) begin
				rv_q <= 1'b0;
			end

			if (do_write) begin
				count_q[req_bank] <= count_q[req_bank] + 1'b1;
			end

			if (tick_go) begin
				vis_q <= tick_end ? '0 : vis_q + 1'b1;
				if (emit_c && !start) begin
					sv_q[vis_q] <= 1'b0;
				end
				if (start) begin
					sv_q[vis_q]    <= 1'b1;
					cd_q[vis_q]    <= dly;
					count_q[vis_q] <= count_q[vis_q] - 1'b1;
					if (head_inc >= (PTR_W+1)'(QUEUE_DEPTH)) begin
						head_q[vis_q] <= '0;
					end else begin
						head_q[vis_q] <= head_inc[PTR_W-1:0];
					end
				end else begin
					cd_q[vis_q] <= cd_dec;
				end
			end
		end
	end

	logic count_over;
	always_comb begin
		count_over = 1'b0;
		for (int i = 0; i < NUM_BANKS; i++) begin
			if (count_q[i] > CNT_W'(QUEUE_DEPTH)) begin
				count_over = 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!count_over)
		else $error("bank queue count above depth");

	a_cap_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_go && start) |=> cap_pend_q)
		else $error("head read not captured");

	a_mid_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(vis_q != '0) |-> (cmd_valid && cmd.is_tick))
		else $error("bank walk without a tick command");

	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && res_q.dropped) |-> res_q.last)
		else $error("drop beat without last");

endmodule

[src/bank_interleaved_request_scheduler.sv]
// Bank interleaved request scheduler. A request beat is dealt to the next of the
// first banks_in_use banks and queued there (a full queue yields one dropped
// result); a tick beat walks the active banks, reporting finished requests and
// starting queue heads, one active bank at a time. A completion or a drop that
// finds the result register still holding an untaken beat waits until that beat
// is taken. The front end accepts a beat per cycle while the two-entry command
// queue has room. Queue storage needs no clearing after reset.

module bank_interleaved_request_scheduler import birs_pkg::*; #(
	parameter int NUM_BANKS   = DEF_NUM_BANKS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  cfg_index_t  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

	logic [15:0]     row_open_delay_q;
	logic [2:0]      banks_in_use_q;
	logic [3:0]      n_wide;
	logic [BANK_W:0] n_act;
	logic [15:0]     dly;

	logic push;
	logic push_ready;
	cmd_t push_cmd;
	logic cmd_valid;
	logic pop;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_open_delay_q <= ROW_OPEN_DELAY_RST;
			banks_in_use_q   <= BANKS_IN_USE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROW_OPEN_DELAY: row_open_delay_q <= cfg_data;
				CFG_BANKS_IN_USE:   banks_in_use_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		n_wide = {1'b0, banks_in_use_q};
		if (n_wide == 4'd0) begin
			n_wide = 4'd1;
		end else if (n_wide > 4'(NUM_BANKS)) begin
			n_wide = 4'(NUM_BANKS);
		end
		n_act = n_wide[BANK_W:0];
		dly   = (row_open_delay_q == 16'd0) ? 16'd1 : row_open_delay_q;
	end

	birs_front #(
		.NUM_BANKS (NUM_BANKS),
		.BANK_W    (BANK_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.n_act      (n_act),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	birs_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.cmd_valid  (cmd_valid),
		.pop        (pop),
		.cmd        (cmd)
	);

	birs_back #(
		.NUM_BANKS   (NUM_BANKS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS),
		.BANK_W      (BANK_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.pop          (pop),
		.n_act        (n_act),
		.dly          (dly),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// testbench for bank_interleaved_request_scheduler: directed table, then random phases
// checks every result beat against a bank queue predictor; depends on birs_pkg and the rtl

module tb_top;
	import birs_pkg::*;

	localparam int NB           = DEF_NUM_BANKS;
	localparam int QD           = DEF_QUEUE_DEPTH;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASES       = 6;
	localparam int PHASE_BEATS  = 33;

	typedef struct {
		bit          is_write;
		cfg_index_t  reg_idx;
		logic [15:0] reg_val;
		item_t       beat;
		int          n_fixed;
		result_t     fixed;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_index_t  cfg_index;
	logic [15:0] cfg_data;

	// predicted block state
	logic [15:0] m_delay;
	logic [2:0]  m_banks;
	logic [1:0]  next_b;
	logic [7:0]  q_mem [NB][QD];
	logic [3:0]  q_head [NB];
	logic [4:0]  q_cnt [NB];
	logic [7:0]  srv_id [NB];
	bit          serving [NB];
	logic [15:0] busy [NB];

	result_t     beat_reports[$];
	result_t     bank_reports[$];
	plan_row_t   plan[$];

	int          fix_n;
	result_t     fix_res;
	bit          idle_on = 1'b1;
	int          errors = 0;
	int          quiet = 0;

	int ph_delay [PHASES] = '{1, 3, 0, 2, 6, 65535};
	int ph_banks [PHASES] = '{4, 7, 3, 16'hfff9, 4, 2};
	int ph_tick  [PHASES] = '{50, 40, 55, 20, 70, 50};
	bit ph_idle  [PHASES] = '{1, 0, 1, 1, 1, 1};

	bank_interleaved_request_scheduler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (!idle_on || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic void schedule_beat(item_t it);
		int      active;
		int      b;
		result_t rep;
		beat_reports.delete();
		active = (m_banks == 3'd0) ? 1 : (m_banks > NB) ? NB : int'(m_banks);
		if (it.req_type == REQ_NEW) begin
			b = (int'(next_b) >= active) ? 0 : int'(next_b);
			next_b = (b + 1 >= active) ? 2'd0 : 2'(b + 1);
			if (q_cnt[b] >= QD) begin
				rep.done_id   = it.request_id;
				rep.done_bank = 2'(b);
				rep.dropped   = 1'b1;
				rep.last      = 1'b1;
				beat_reports = {beat_reports, rep};
			end else begin
				q_mem[b][(int'(q_head[b]) + int'(q_cnt[b])) % QD] = it.request_id;
				q_cnt[b] = q_cnt[b] + 5'd1;
			end
		end else begin
			for (int i = 0; i < active; i++) begin
				if (busy[i] != 16'd0)
					busy[i] = busy[i] - 16'd1;
				if (busy[i] == 16'd0) begin
					if (serving[i]) begin
						rep.done_id   = srv_id[i];
						rep.done_bank = 2'(i);
						rep.dropped   = 1'b0;
						rep.last      = 1'b0;
						beat_reports = {beat_reports, rep};
						serving[i] = 1'b0;
					end
					if (q_cnt[i] != 5'd0) begin
						srv_id[i]  = q_mem[i][q_head[i]];
						serving[i] = 1'b1;
						q_head[i]  = 4'((int'(q_head[i]) + 1) % QD);
						q_cnt[i]   = q_cnt[i] - 5'd1;
						busy[i]    = (m_delay == 16'd0) ? 16'd1 : m_delay;
					end
				end
			end
			if (beat_reports.size() != 0) begin
				rep = beat_reports.pop_back();
				rep.last = 1'b1;
				beat_reports = {beat_reports, rep};
			end
		end
	endfunction

	function automatic void report_error(string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic void add_beat(req_kind_t kind, logic [7:0] id, int nfix, result_t fix);
		plan_row_t row;
		row.is_write        = 1'b0;
		row.reg_idx         = CFG_ROW_OPEN_DELAY;
		row.reg_val         = '0;
		row.beat.req_type   = kind;
		row.beat.request_id = id;
		row.n_fixed         = nfix;
		row.fixed           = fix;
		plan = {plan, row};
	endfunction

	function automatic void add_write(cfg_index_t idx, logic [15:0] val);
		plan_row_t row;
		row.is_write = 1'b1;
		row.reg_idx  = idx;
		row.reg_val  = val;
		row.beat     = '0;
		row.n_fixed  = -1;
		row.fixed    = '0;
		plan = {plan, row};
	endfunction

	task automatic send_beat(input item_t it, input int nfix, input result_t fix);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		fix_n      <= nfix;
		fix_res    <= fix;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	// wait for all reports, then let the engine finish any silent work
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (bank_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int stall;
		result_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				schedule_beat(item);
				if (fix_n >= 0) begin
					beat_reports.delete();
					if (fix_n > 0)
						beat_reports = {beat_reports, fix_res};
				end
				foreach (beat_reports[i])
					bank_reports = {bank_reports, beat_reports[i]};
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_ROW_OPEN_DELAY)
					m_delay = cfg_data;
				else
					m_banks = cfg_data[2:0];
			end
			if (result_valid && result_ready) begin
				if (bank_reports.size() == 0) begin
					report_error($sformatf("unexpected result id %02h bank %0d drop %0d last %0d",
						result.done_id, result.done_bank, result.dropped, result.last));
				end else begin
					want = bank_reports.pop_front();
					if (want.done_id !== result.done_id || want.done_bank !== result.done_bank ||
					    want.dropped !== result.dropped || want.last !== result.last) begin
						report_error($sformatf({"result mismatch: want id %02h bank %0d drop %0d",
							" last %0d, got id %02h bank %0d drop %0d last %0d"},
							want.done_id, want.done_bank, want.dropped, want.last,
							result.done_id, result.done_bank, result.dropped, result.last));
					end
				end
			end
		end
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
			if (quiet >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		item_t beat;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_ROW_OPEN_DELAY;
		cfg_data   <= '0;
		fix_n      <= -1;
		fix_res    <= '0;
		arst_n     <= 1'b0;

		m_delay = ROW_OPEN_DELAY_RST;
		m_banks = BANKS_IN_USE_RST;
		next_b  = 2'd0;
		for (int i = 0; i < NB; i++) begin
			q_head[i]  = '0;
			q_cnt[i]   = '0;
			serving[i] = 1'b0;
			busy[i]    = '0;
		end

		// empty tick, one request to each of the first three banks, pointer restart after shrinking the bank count
		add_beat(REQ_TICK, 8'h00, 0, '0);
		add_beat(REQ_NEW, 8'h00, 0, '0);
		add_beat(REQ_NEW, 8'hff, 0, '0);
		add_beat(REQ_NEW, 8'h55, 0, '0);
		add_write(CFG_ROW_OPEN_DELAY, 16'd0);
		add_write(CFG_BANKS_IN_USE, 16'd2);
		add_beat(REQ_NEW, 8'haa, 0, '0);
		add_beat(REQ_TICK, 8'h3c, 0, '0);
		add_beat(REQ_TICK, 8'hc3, -1, '0);
		// zero banks acts as one, then fill bank 0 until it drops
		add_write(CFG_BANKS_IN_USE, 16'd0);
		add_beat(REQ_TICK, 8'h00, 1,
			'{done_id: 8'haa, done_bank: 2'd0, dropped: 1'b0, last: 1'b1});
		repeat (QD) add_beat(REQ_NEW, 8'($urandom()), 0, '0);
		add_beat(REQ_NEW, 8'h81, 1,
			'{done_id: 8'h81, done_bank: 2'd0, dropped: 1'b1, last: 1'b1});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].is_write)
				write_reg(plan[r].reg_idx, plan[r].reg_val);
			else
				send_beat(plan[r].beat, plan[r].n_fixed, plan[r].fixed);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_reg(CFG_ROW_OPEN_DELAY, 16'(ph_delay[p]));
			write_reg(CFG_BANKS_IN_USE, 16'(ph_banks[p]));
			idle_on = ph_idle[p];
			repeat (PHASE_BEATS) begin
				beat.req_type   = ($urandom_range(0, 99) < ph_tick[p]) ? REQ_TICK : REQ_NEW;
				beat.request_id = 8'($urandom());
				send_beat(beat, -1, '0);
			end
			idle_on = 1'b1;
		end

		settle();
		if (errors == 0 && bank_reports.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
